@@ src/aes_pkg.sv @@
// Package for the AES block encryptor: payload structs, state enum, S-box and
// GF(2^8) helpers. No dependencies.
package aes_pkg;

    typedef struct packed {
        logic [63:0] plain_high;
        logic [63:0] plain_low;
    } t_in_beat;

    typedef struct packed {
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
    } t_out_beat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_LOAD,
        ST_ROUND,
        ST_DONE
    } t_state;

    localparam logic [2:0] REG_KEY_SIZE = 3'd0;
    localparam logic [2:0] REG_KEY_W0   = 3'd1;
    localparam logic [2:0] REG_KEY_W1   = 3'd2;
    localparam logic [2:0] REG_KEY_W2   = 3'd3;
    localparam logic [2:0] REG_KEY_W3   = 3'd4;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

endpackage

@@ src/aes_block_encrypt.sv @@
// AES-128/192/256 encryption top level: APB key registers, key expansion and
// an iterative round unit over a round key RAM. Depends on aes_pkg, aes_ram.
//
//  channel | signals                          | beat taken when
//  input   | i_start, o_busy, i_in            | i_start && !o_busy
//  output  | o_done, o_out                    | o_done (one cycle, no stall)
//  config  | psel penable pwrite paddr pwdata | psel && penable && pwrite
//
// A taken block passes a load state, the round states, where each 128-bit round
// key is two 64-bit RAM reads, and a done state that shows the result. o_busy
// stays high through the done state and falls on the return to idle, so no new
// block starts before the last one is through. After a key write, the first
// block first expands the round keys into the RAM, one 64-bit entry per cycle.
// Reset clears the control state and the APB key registers only.
module aes_block_encrypt #(
    parameter int MAX_ROUNDS = 14
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [5:0]                  paddr,
    input  logic [63:0]                 pwdata,
    output logic [63:0]                 prdata,
    output logic                        pready,
    input  logic                        i_start,
    output logic                        o_busy,
    input  aes_pkg::t_in_beat           i_in,
    output logic                        o_done,
    output aes_pkg::t_out_beat          o_out
);
    import aes_pkg::*;

    localparam int DEPTH = 2 * (MAX_ROUNDS + 1);
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(MAX_ROUNDS + 2);

    logic [1:0]  r_key_size;
    logic [63:0] r_kw [4];
    logic        r_keys_ready;
    t_state      r_state, n_state;

    logic [AW-1:0] r_ecnt, n_ecnt;
    logic [3:0]    r_win_cnt, n_win_cnt;
    logic [255:0]  r_win, n_win;
    logic [7:0]    r_rc, n_rc;
    logic [RW-1:0] r_round, n_round;
    logic [127:0]  r_s, n_s;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [63:0]   ram_wdata, ram_rdata;
    logic          r_half, n_half;
    logic [63:0]   r_khi, n_khi;

    logic [3:0]    nk;
    logic [RW-1:0] nr;
    logic [RW+1:0] nr_full;
    logic [AW-1:0] last_entry;
    logic          cfg_wr;
    logic [2:0]    reg_idx;

    always_comb begin
        case (r_key_size)
            2'd0:    nk = 4'd4;
            2'd1:    nk = 4'd6;
            default: nk = 4'd8;
        endcase
        nr_full = (RW+2)'(nk) + (RW+2)'(6);
        nr = (nr_full > (RW+2)'(MAX_ROUNDS)) ? RW'(MAX_ROUNDS) : nr_full[RW-1:0];
        last_entry = AW'(2 * nr + 1);
    end

    assign reg_idx = paddr[5:3];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb begin
        case (reg_idx)
            REG_KEY_SIZE: prdata = {62'd0, r_key_size};
            REG_KEY_W0:   prdata = r_kw[0];
            REG_KEY_W1:   prdata = r_kw[1];
            REG_KEY_W2:   prdata = r_kw[2];
            REG_KEY_W3:   prdata = r_kw[3];
            default:      prdata = 64'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_size   <= 2'd0;
            r_kw[0]      <= 64'd0;
            r_kw[1]      <= 64'd0;
            r_kw[2]      <= 64'd0;
            r_kw[3]      <= 64'd0;
            r_keys_ready <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (reg_idx)
                    REG_KEY_SIZE: r_key_size <= pwdata[1:0];
                    REG_KEY_W0:   r_kw[0] <= pwdata;
                    REG_KEY_W1:   r_kw[1] <= pwdata;
                    REG_KEY_W2:   r_kw[2] <= pwdata;
                    REG_KEY_W3:   r_kw[3] <= pwdata;
                    default:      ;
                endcase
                if (reg_idx <= REG_KEY_W3) begin
                    r_keys_ready <= 1'b0;
                end
            end else if (r_state == ST_EXPAND && r_ecnt == last_entry) begin
                r_keys_ready <= 1'b1;
            end
        end
    end

    aes_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_rk (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Key expansion: a sliding window of the last Nk words (up to eight); two new words
    // per cycle leave through the RAM. Window word j is bits [255-32j -: 32].
    function automatic logic [31:0] next_word(input logic [255:0] win,
                                              input logic [3:0] k,
                                              input logic [3:0] pos,
                                              input logic [7:0] rc);
        logic [31:0] t, old;
        t   = win[255 - 32*(k-1) -: 32];
        old = win[255 -: 32];
        if (pos == 4'd0) begin
            t = sub_word({t[23:0], t[31:24]}) ^ {rc, 24'd0};
        end else if (k == 4'd8 && pos == 4'd4) begin
            t = sub_word(t);
        end
        return old ^ t;
    endfunction

    // One AES round on the state; at round index 1 the initial key addition (first_ark) takes its place.
    function automatic logic [127:0] round_fn(input logic [127:0] s,
                                              input logic [127:0] k,
                                              input logic last);
        logic [7:0] b [16];
        logic [7:0] t [16];
        logic [127:0] o;
        for (int i = 0; i < 16; i++) b[i] = s[127 - 8*i -: 8];
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[r + 4*c] = SBOX[b[r + 4*((c + r) % 4)]];
            end
        end
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                b[4*c]   = xtime(t[4*c]) ^ xtime(t[4*c+1]) ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
                b[4*c+1] = t[4*c] ^ xtime(t[4*c+1]) ^ xtime(t[4*c+2]) ^ t[4*c+2] ^ t[4*c+3];
                b[4*c+2] = t[4*c] ^ t[4*c+1] ^ xtime(t[4*c+2]) ^ xtime(t[4*c+3]) ^ t[4*c+3];
                b[4*c+3] = xtime(t[4*c]) ^ t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ xtime(t[4*c+3]);
            end
        end else begin
            for (int i = 0; i < 16; i++) b[i] = t[i];
        end
        for (int i = 0; i < 16; i++) o[127 - 8*i -: 8] = b[i];
        return o ^ k;
    endfunction

    logic [31:0] w_a, w_b;
    logic [255:0] win_a;
    logic [3:0] pos_a, pos_b;
    logic rc_step_a, rc_step_b;

    always_comb begin
        pos_a = r_win_cnt;
        pos_b = (r_win_cnt + 4'd1 == nk) ? 4'd0 : r_win_cnt + 4'd1;
        w_a   = next_word(r_win, nk, pos_a, r_rc);
        rc_step_a = (pos_a == 4'd0);
        win_a = r_win;
        win_a = (win_a << 32);
        case (nk)
            4'd4:    win_a[255-32*3 -: 32] = w_a;
            4'd6:    win_a[255-32*5 -: 32] = w_a;
            default: win_a[31:0] = w_a;
        endcase
        w_b = next_word(win_a, nk, pos_b, rc_step_a ? xtime(r_rc) : r_rc);
        rc_step_b = (pos_b == 4'd0);
    end

    always_comb begin
        n_state   = r_state;
        n_ecnt    = r_ecnt;
        n_win     = r_win;
        n_win_cnt = r_win_cnt;
        n_rc      = r_rc;
        n_round   = r_round;
        n_s       = r_s;
        n_half    = r_half;
        n_khi     = r_khi;
        ram_we    = 1'b0;
        ram_waddr = r_ecnt;
        ram_wdata = 64'd0;
        ram_raddr = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_s = {i_in.plain_high, i_in.plain_low};
                    n_ecnt = '0;
                    n_win = {r_kw[0], r_kw[1], r_kw[2], r_kw[3]};
                    n_win_cnt = 4'd0;
                    n_rc = 8'h01;
                    n_half = 1'b0;
                    n_state = r_keys_ready ? ST_LOAD : ST_EXPAND;
                end
            end
            ST_EXPAND: begin
                ram_we = 1'b1;
                if (r_ecnt < AW'(nk[3:1])) begin
                    ram_wdata = r_kw[r_ecnt[1:0]];
                end else begin
                    ram_wdata = {w_a, w_b};
                    n_win = win_a << 32;
                    case (nk)
                        4'd4:    n_win[255-32*3 -: 32] = w_b;
                        4'd6:    n_win[255-32*5 -: 32] = w_b;
                        default: n_win[31:0] = w_b;
                    endcase
                    n_win_cnt = (pos_b + 4'd1 == nk) ? 4'd0 : pos_b + 4'd1;
                    n_rc = r_rc;
                    if (rc_step_a) n_rc = xtime(n_rc);
                    if (rc_step_b) n_rc = xtime(n_rc);
                end
                if (r_ecnt == last_entry) begin
                    n_state = ST_LOAD;
                end else begin
                    n_ecnt = r_ecnt + AW'(1);
                end
            end
            ST_LOAD: begin
                ram_raddr = '0;
                n_half = 1'b1;
                n_round = '0;
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                if (!r_half) begin
                    ram_raddr = AW'(2 * r_round);
                    n_half = 1'b1;
                end else begin
                    ram_raddr = AW'(2 * r_round + 1);
                    n_khi = ram_rdata;
                    n_half = 1'b0;
                end
                if (!r_half && r_round != '0) begin
                    n_s = round_fn(r_s, {r_khi, ram_rdata}, r_round == nr + RW'(1));
                    if (r_round == nr + RW'(1)) begin
                        n_state = ST_DONE;
                    end
                end
                if (r_half) begin
                    n_round = r_round + RW'(1);
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // The first key addition has no SubBytes; handle it through a separate
    // register path when the first key pair arrives.
    logic first_ark;
    assign first_ark = (r_state == ST_ROUND) && !r_half && (r_round == RW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_ecnt    <= n_ecnt;
        r_win     <= n_win;
        r_win_cnt <= n_win_cnt;
        r_rc      <= n_rc;
        r_round   <= n_round;
        r_half    <= n_half;
        r_khi     <= n_khi;
        if (first_ark) begin
            r_s <= r_s ^ {r_khi, ram_rdata};
        end else begin
            r_s <= n_s;
        end
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_done = (r_state == ST_DONE);
    assign o_out  = {r_s[127:64], r_s[63:0]};

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |=> (r_state == ST_IDLE))
        else $error("done not followed by idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) |-> r_keys_ready)
        else $error("round start without keys");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXPAND) |-> (r_ecnt <= last_entry))
        else $error("expansion ran past the last entry");
endmodule

@@ src/aes_ram.sv @@
// Generic simple dual-port synchronous RAM (one write port, one read port) with registered read.
// No dependencies.
module aes_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 30
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ tb/sv/tb_aes_block_encrypt.sv @@
// Self-checking testbench for aes_block_encrypt: drives plaintext beats and APB
// key writes, predicts ciphertext with its own AES model. Depends on aes_pkg, aes_block_encrypt.
module tb_aes_block_encrypt;
    import aes_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        i_start;
    logic        o_busy;
    t_in_beat    i_in;
    logic        o_done;
    t_out_beat   o_out;

    aes_block_encrypt dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready), .i_start(i_start), .o_busy(o_busy), .i_in(i_in),
        .o_done(o_done), .o_out(o_out)
    );

    localparam int NR_CAP = 14;

    logic [7:0]  sb [256];
    logic [1:0]  key_size_q;
    logic [63:0] key_q [4];
    logic [63:0] rk [2*(NR_CAP+1)];
    bit          rk_valid;
    t_out_beat   cipher_q [$];
    int          errors;

    initial begin
        for (int i = 0; i < 256; i++) sb[i] = SBOX[i];
    end

    function automatic logic [7:0] gmul2(logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sbox_word(logic [31:0] w);
        return {sb[w[31:24]], sb[w[23:16]], sb[w[15:8]], sb[w[7:0]]};
    endfunction

    function automatic int key_words();
        return (key_size_q == 2'd0) ? 4 : (key_size_q == 2'd1) ? 6 : 8;
    endfunction

    function automatic int nrounds();
        int n;
        n = key_words() + 6;
        return n > NR_CAP ? NR_CAP : n;
    endfunction

    task automatic expand_round_keys();
        logic [31:0] w [4*(NR_CAP+1)];
        logic [31:0] t;
        logic [7:0]  rc;
        int nk, total;
        nk = key_words();
        total = 4 * (nrounds() + 1);
        rc = 8'h01;
        for (int i = 0; i < nk && i < total; i++)
            w[i] = i[0] ? key_q[i/2][31:0] : key_q[i/2][63:32];
        for (int i = nk; i < total; i++) begin
            t = w[i-1];
            if (i % nk == 0) begin
                t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = gmul2(rc);
            end else if (nk > 6 && i % nk == 4) begin
                t = sbox_word(t);
            end
            w[i] = w[i-nk] ^ t;
        end
        for (int i = 0; i + 1 < total; i += 2) rk[i/2] = {w[i], w[i+1]};
        rk_valid = 1;
    endtask

    task automatic encrypt_block(t_in_beat pt);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3;
        logic [127:0] blk;
        t_out_beat ct;
        int nr;
        if (!rk_valid) expand_round_keys();
        nr = nrounds();
        blk = pt;
        for (int k = 0; k < 16; k++) s[k] = blk[127-8*k -: 8];
        for (int r = 0; r <= nr; r++) begin
            if (r > 0) begin
                for (int c = 0; c < 4; c++)
                    for (int j = 0; j < 4; j++)
                        t[j+4*c] = sb[s[j + 4*((c+j)%4)]];
                s = t;
                if (r < nr) begin
                    for (int c = 0; c < 4; c++) begin
                        a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
                        s[4*c]   = gmul2(a0) ^ gmul2(a1) ^ a1 ^ a2 ^ a3;
                        s[4*c+1] = a0 ^ gmul2(a1) ^ gmul2(a2) ^ a2 ^ a3;
                        s[4*c+2] = a0 ^ a1 ^ gmul2(a2) ^ gmul2(a3) ^ a3;
                        s[4*c+3] = gmul2(a0) ^ a0 ^ a1 ^ a2 ^ gmul2(a3);
                    end
                end
            end
            for (int k = 0; k < 16; k++)
                s[k] ^= rk[2*r + k/8][63-8*(k%8) -: 8];
        end
        for (int k = 0; k < 16; k++) blk[127-8*k -: 8] = s[k];
        ct = blk;
        cipher_q.push_back(ct);
    endtask

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #100ms;
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        t_out_beat exp_ct;
        if (i_rst_n && o_done) begin
            if (cipher_q.size() == 0) begin
                $display("%0t: unexpected beat, expected none actual %h", $time, o_out);
                errors++;
            end else begin
                exp_ct = cipher_q.pop_front();
                if (o_out.cipher_high !== exp_ct.cipher_high) begin
                    $display("%0t: cipher_high expected %h actual %h",
                             $time, exp_ct.cipher_high, o_out.cipher_high);
                    errors++;
                end
                if (o_out.cipher_low !== exp_ct.cipher_low) begin
                    $display("%0t: cipher_low expected %h actual %h",
                             $time, exp_ct.cipher_low, o_out.cipher_low);
                    errors++;
                end
            end
        end
    end

    task automatic wait_drained();
        while (cipher_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        psel    <= 1;
        pwrite  <= 1;
        penable <= 0;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
        case (idx)
            REG_KEY_SIZE: key_size_q = val[1:0];
            REG_KEY_W0:   key_q[0] = val;
            REG_KEY_W1:   key_q[1] = val;
            REG_KEY_W2:   key_q[2] = val;
            REG_KEY_W3:   key_q[3] = val;
            default: return;
        endcase
        rk_valid = 0;
    endtask

    task automatic load_key(logic [1:0] ks, logic [63:0] k0, logic [63:0] k1,
                            logic [63:0] k2, logic [63:0] k3);
        write_reg(REG_KEY_SIZE, {62'h0, ks});
        write_reg(REG_KEY_W0, k0);
        write_reg(REG_KEY_W1, k1);
        write_reg(REG_KEY_W2, k2);
        write_reg(REG_KEY_W3, k3);
    endtask

    // Start stays high from beat to beat inside a burst.
    task automatic send_block(t_in_beat pt, bit hold);
        i_start <= 1;
        i_in    <= pt;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        encrypt_block(pt);
        if (!hold) i_start <= 0;
    endtask

    function automatic logic [63:0] rand64();
        case ($urandom_range(0, 7))
            0: return 64'h0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_random(int n);
        int burst;
        int gap;
        t_in_beat pt;
        while (n > 0) begin
            burst = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 30) : 0;
            for (int b = 0; b < burst && n > 0; b++) begin
                pt.plain_high = rand64();
                pt.plain_low  = rand64();
                n--;
                send_block(pt, (b < burst - 1 || gap == 0) && n > 0);
            end
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic test_fips_vectors();
        t_in_beat pt;
        pt = {64'h0011223344556677, 64'h8899aabbccddeeff};
        load_key(2'd0, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h0, 64'h0);
        send_block(pt, 0);
        wait_drained();
        load_key(2'd1, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                 64'h1011121314151617, 64'h0);
        send_block(pt, 1);
        send_block(pt, 0);
        wait_drained();
        load_key(2'd2, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                 64'h1011121314151617, 64'h18191a1b1c1d1e1f);
        send_block(pt, 0);
        wait_drained();
    endtask

    task automatic test_field_extremes();
        load_key(2'd0, '1, '1, '1, '1);
        send_block('0, 1);
        send_block('1, 1);
        send_block({64'h0, 64'hffffffffffffffff}, 1);
        send_block({64'hffffffffffffffff, 64'h0}, 0);
        wait_drained();
        load_key(2'd2, 64'h0, 64'h0, 64'h0, 64'h0);
        send_block('1, 1);
        send_block('0, 0);
        wait_drained();
    endtask

    task automatic test_special_writes();
        t_in_beat pt;
        pt = {64'h0123456789abcdef, 64'hfedcba9876543210};
        write_reg(REG_KEY_SIZE, 64'h3);
        send_block(pt, 0);
        wait_drained();
        write_reg(REG_KEY_W1, key_q[1]);
        send_block(pt, 0);
        wait_drained();
        write_reg(3'd5, 64'hdeadbeefdeadbeef);
        write_reg(3'd7, '1);
        send_block(pt, 0);
        wait_drained();
    endtask

    task automatic test_random_keys();
        for (int ph = 0; ph < 24; ph++) begin
            load_key(2'($urandom_range(0, 3)), rand64(), rand64(), rand64(), rand64());
            send_random(68);
            wait_drained();
        end
    endtask

    initial begin
        errors = 0;
        rk_valid = 0;
        key_size_q = 0;
        for (int i = 0; i < 4; i++) key_q[i] = 0;
        i_rst_n = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        i_start = 0;
        i_in = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        test_fips_vectors();
        test_field_extremes();
        test_special_writes();
        test_random_keys();
        wait_drained();
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
